// File: sv/zero_crossing_frequency_estimator_defines.svh
// Assertion helpers for the zero crossing frequency estimator.
// Both expect clk and arst_n in scope.
`ifndef ZERO_CROSSING_FREQUENCY_ESTIMATOR_DEFINES_SVH
`define ZERO_CROSSING_FREQUENCY_ESTIMATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define ZCFE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("zcfe assertion failed");
`define ZCFE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("zcfe assertion failed");
`else
`define ZCFE_ASSERT(lbl, prop)
`define ZCFE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/zcfe_pkg.sv
package zcfe_pkg;

	localparam int SMP_W       = 16;
	localparam int FRAC_W      = 16;
	localparam int OUT_FRAC_W  = 8;
	localparam int CNT_W       = 12;
	localparam int RATE_W      = 18;
	localparam int QUO_W       = 26;
	localparam int PROD_W      = CNT_W + RATE_W;
	localparam int DVD_W       = PROD_W + FRAC_W + OUT_FRAC_W;
	localparam int DIV1_NUM_W  = SMP_W + FRAC_W;
	localparam int ITER_W      = $clog2(DVD_W + 1);
	localparam int MAX_BLOCK_DEF = 4096;

	localparam logic [ITER_W-1:0] DIV1_ITERS = ITER_W'(DIV1_NUM_W);
	localparam logic [ITER_W-1:0] DIV2_ITERS = ITER_W'(DVD_W);

	localparam logic [QUO_W-1:0]  FREQ_MAX   = '1;
	localparam logic [CNT_W-1:0]  COUNT_MAX  = '1;
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

	// APB map
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_SAMPLE_RATE = 1'b0;   // word index, paddr[2]

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [ITER_W-1:0] iters;
	} div_cmd_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic             ovf;
		logic [QUO_W-1:0] quotient;
	} div_sts_t;

endpackage

// File: sv/zcfe_apb.sv
module zcfe_apb (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [zcfe_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [zcfe_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [zcfe_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output logic [zcfe_pkg::RATE_W-1:0]      sample_rate
);
	import zcfe_pkg::*;

	logic [RATE_W-1:0] rate_q;
	logic              hit;

	// word-aligned decode, byte offset ignored
	assign hit = (paddr[2] == REG_SAMPLE_RATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (psel && penable && pwrite && hit) begin
			rate_q <= pwdata[RATE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = APB_DATA_W'(rate_q);
		end
	end

	assign pready      = 1'b1;
	assign sample_rate = rate_q;

endmodule

// File: sv/zcfe_div.sv
`include "zero_crossing_frequency_estimator_defines.svh"

// Restoring divider, one quotient bit per cycle. Dividend is consumed from
// its MSB; iters sets how many bits. Quotient bits shifted past the top
// set a sticky overflow.
module zcfe_div #(
	parameter int DVS_W = 29
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  zcfe_pkg::div_cmd_t   cmd,
	input  logic [DVS_W-1:0]     divisor,
	output zcfe_pkg::div_sts_t   sts
);
	import zcfe_pkg::*;

	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [QUO_W-1:0]  quo_q;
	logic              ovf_q;
	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] cnt_q;

	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic           fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = !diff[DVS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= cmd.iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - ITER_W'(1);
			if (cnt_q == ITER_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q <= cmd.dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], fits};
			ovf_q <= ovf_q | quo_q[QUO_W-1];
		end
	end

	assign sts.busy     = busy_q;
	assign sts.done     = done_q;
	assign sts.ovf      = ovf_q;
	assign sts.quotient = quo_q;

	`ZCFE_ASSERT(a_start_idle, cmd.start |-> !busy_q)
	`ZCFE_ASSERT(a_rem_below, busy_q |-> rem_q < dvs_q)
	`ZCFE_ASSERT_NEXT(a_done_last, busy_q && !cmd.start && cnt_q == ITER_W'(1), done_q && !busy_q)

endmodule

// File: sv/zero_crossing_frequency_estimator.sv
// Zero crossing frequency estimator.
// Input channel (in_valid/in_ready): one audio word per sample, sample is
// signed 16 bit, last_sample marks the final word of an analysis block.
// Output channel (out_valid/out_ready): one word per block, issued for the
// word carrying last_sample: frequency_q8 (Hz * 256, saturated to 26 bits,
// 0 with fewer than two crossings) and crossings (upward crossing count).
// APB port: register 0 at byte address 0 holds sample_rate (18 bits).
// Work per sample; both divides use the one shared bit-serial divider:
//   plain sample: taken, in_ready stays high
//   sample ending an upward crossing: 32-bit fraction divide
//   last sample: multiply state, 54-bit divide if freq_ok, output load
// A last sample that also ends a crossing does the fraction divide first.
// A finished result sits in the output register; the next block's samples
// are taken while it waits. If out_ready stays low and a second result is
// ready, the block holds in its output state with in_ready low.
// Reset: sample_rate returns to 48000 and block state is cleared; in_ready
// is already high while arst_n is low.
`include "zero_crossing_frequency_estimator_defines.svh"

module zero_crossing_frequency_estimator #(
	parameter int MAX_BLOCK = zcfe_pkg::MAX_BLOCK_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [zcfe_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [zcfe_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [zcfe_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [zcfe_pkg::SMP_W-1:0] sample,
	input  logic                             last_sample,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [zcfe_pkg::QUO_W-1:0]       frequency_q8,
	output logic [zcfe_pkg::CNT_W-1:0]       crossings
);
	import zcfe_pkg::*;

	// index saturates at MAX_BLOCK; base index of a crossing is below it
	localparam int IDX_W  = $clog2(MAX_BLOCK + 1);
	localparam int BASE_W = $clog2(MAX_BLOCK);
	localparam int POS_W  = BASE_W + FRAC_W + 1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV1 = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DIV2 = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;

	logic [RATE_W-1:0] sample_rate;

	// block state
	logic [SMP_W-1:0]  prev_q;
	logic              have_prev_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BASE_W-1:0] base_q;
	logic [POS_W-1:0]  first_pos_q;
	logic [POS_W-1:0]  last_pos_q;
	logic [CNT_W-1:0]  count_q;
	logic              last_q;
	logic [QUO_W-1:0]  res_freq_q;

	// output register
	logic              out_valid_q;
	logic [QUO_W-1:0]  freq_out_q;
	logic [CNT_W-1:0]  cross_out_q;

	div_cmd_t          dcmd;
	div_sts_t          dsts;
	logic [POS_W-1:0]  dvs;

	logic              accept;
	logic              crossing;
	logic [SMP_W-1:0]  neg_prev;
	logic [SMP_W:0]    denom;
	logic              freq_ok;
	logic [POS_W-1:0]  span;
	logic [PROD_W-1:0] prod;
	logic [POS_W-1:0]  new_pos;
	logic              out_load;

	zcfe_apb u_apb (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.sample_rate (sample_rate)
	);

	zcfe_div #(
		.DVS_W (POS_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (dcmd),
		.divisor (dvs),
		.sts     (dsts)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// upward crossing: previous negative, current zero or more, index below MAX_BLOCK
	assign crossing = have_prev_q && (idx_q < IDX_W'(MAX_BLOCK)) && prev_q[SMP_W-1]
		&& !sample[SMP_W-1];
	assign neg_prev = SMP_W'(-prev_q);
	assign denom    = {sample[SMP_W-1], sample} - {prev_q[SMP_W-1], prev_q};

	assign freq_ok = (count_q >= CNT_W'(2)) && (last_pos_q > first_pos_q);
	assign span    = last_pos_q - first_pos_q;
	assign prod    = PROD_W'(count_q - CNT_W'(1)) * PROD_W'(sample_rate);

	// crossing position: base index in Q.16 plus fraction (up to 1.0)
	assign new_pos = POS_W'({base_q, FRAC_W'(0)}) + POS_W'(dsts.quotient[FRAC_W:0]);

	always_comb begin
		dcmd.start = (accept && crossing) || (state_q == ST_MUL && freq_ok);
		if (state_q == ST_MUL) begin
			dcmd.dividend = {prod, (FRAC_W + OUT_FRAC_W)'(0)};
			dcmd.iters    = DIV2_ITERS;
			dvs           = span;
		end else begin
			dcmd.dividend = DVD_W'({neg_prev, FRAC_W'(0)}) << (DVD_W - DIV1_NUM_W);
			dcmd.iters    = DIV1_ITERS;
			dvs           = POS_W'(denom[SMP_W-1:0]);
		end
	end

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			idx_q       <= '0;
			first_pos_q <= '0;
			last_pos_q  <= '0;
			count_q     <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_q      <= sample;
						have_prev_q <= 1'b1;
						last_q      <= last_sample;
						if (idx_q < IDX_W'(MAX_BLOCK)) begin
							idx_q <= idx_q + IDX_W'(1);
						end
						if (crossing) begin
							state_q <= ST_DIV1;
						end else if (last_sample) begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_DIV1: begin
					if (dsts.done) begin
						if (count_q == '0) begin
							first_pos_q <= new_pos;
						end
						last_pos_q <= new_pos;
						if (count_q != COUNT_MAX) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= last_q ? ST_MUL : ST_IDLE;
					end
				end
				ST_MUL: begin
					state_q <= freq_ok ? ST_DIV2 : ST_OUT;
				end
				ST_DIV2: begin
					if (dsts.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						prev_q      <= '0;
						have_prev_q <= 1'b0;
						idx_q       <= '0;
						first_pos_q <= '0;
						last_pos_q  <= '0;
						count_q     <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= BASE_W'(idx_q - IDX_W'(1));
		end
		if (state_q == ST_MUL && !freq_ok) begin
			res_freq_q <= '0;
		end else if (state_q == ST_DIV2 && dsts.done) begin
			res_freq_q <= dsts.ovf ? FREQ_MAX : dsts.quotient;
		end
		if (out_load) begin
			freq_out_q  <= res_freq_q;
			cross_out_q <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign frequency_q8 = freq_out_q;
	assign crossings    = cross_out_q;

	`ZCFE_ASSERT(a_ready_div_idle, in_ready |-> !dsts.busy)
	`ZCFE_ASSERT(a_pos_order, first_pos_q <= last_pos_q)
	`ZCFE_ASSERT_NEXT(a_out_load, out_load, out_valid && state_q == ST_IDLE)

endmodule

// File: tb/sv/zero_crossing_frequency_estimator_tb.sv
`timescale 1ns / 1ps

module zero_crossing_frequency_estimator_tb;
	import zcfe_pkg::*;

	// Run control
	localparam int CYCLE_LIMIT   = 1_500_000;
	localparam int SETTLE_CYCLES = 120;        // covers a crossing divide plus a final divide
	localparam int HOLD_CYCLES   = 1500;       // long receiver hold-off, fills the block
	localparam int NUM_PHASES    = 7;
	localparam int HOLD_PHASE    = 2;
	localparam int NUM_DIRECTED  = 23;

	localparam logic [APB_ADDR_W-1:0] RATE_ADDR = {REG_SAMPLE_RATE, 2'b00};

	// One result word: frequency in Q.8 hertz and the crossing count
	typedef struct packed {
		logic [QUO_W-1:0] freq;
		logic [CNT_W-1:0] count;
	} block_result_t;

	// Directed row: one input word, plus a typed result where it is obvious
	typedef struct packed {
		logic signed [SMP_W-1:0] smp;
		logic                    last;
		logic                    typed;
		logic [QUO_W-1:0]        freq;
		logic [CNT_W-1:0]        count;
	} stim_row_t;

	// DUT signals; those driven by the bench are known from time zero
	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]    paddr = '0;
	logic [APB_DATA_W-1:0]    pwdata = '0;
	logic [APB_DATA_W-1:0]    prdata;
	logic                     pready;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [SMP_W-1:0]  sample = '0;
	logic                     last_sample = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [QUO_W-1:0]         frequency_q8;
	logic [CNT_W-1:0]         crossings;

	// Predictor state: mirrors the estimator's block state and its register
	int unsigned              est_rate = 48000;
	logic signed [SMP_W-1:0]  est_prev = '0;
	bit                       est_have_prev = 1'b0;
	int unsigned              est_index = 0;
	longint unsigned          est_first_pos = 0;
	bit                       est_first_seen = 1'b0;
	longint unsigned          est_last_pos = 0;
	int unsigned              est_count = 0;

	block_result_t            expected_blocks[$];
	int unsigned              mismatches = 0;
	int unsigned              cycle_count = 0;

	// Idling knobs, percent chance of a burst per word / per cycle
	int unsigned              tx_idle_pct = 0;
	int unsigned              rx_idle_pct = 0;
	int unsigned              rx_hold_cycles = 0;

	// Phase plan: register setting, random word count and idling on each side.
	// Last phase runs with no idling at all.
	int unsigned phase_rate    [NUM_PHASES] = '{48000, 1, 192000, 0, 262143, 96000, 44100};
	int unsigned phase_items   [NUM_PHASES] = '{250, 200, 200, 150, 200, 120, 300};
	int unsigned phase_tx_idle [NUM_PHASES] = '{30, 0, 0, 25, 15, 10, 0};
	int unsigned phase_rx_idle [NUM_PHASES] = '{30, 40, 10, 0, 20, 10, 0};

	// Directed words at the reset rate of 48000 Hz.
	stim_row_t directed_rows [NUM_DIRECTED] = '{
		// single word block: first word has no predecessor
		'{16'sh8000, 1'b1, 1'b1, 26'd0, 12'd0},
		// one crossing, landing exactly on zero: count 1, no frequency
		'{16'sh7FFF, 1'b0, 1'b0, 26'd0, 12'd0},
		'{16'sh8000, 1'b0, 1'b0, 26'd0, 12'd0},
		'{16'sh0000, 1'b1, 1'b1, 26'd0, 12'd1},
		// block ends on a negative word
		'{-16'sd5,   1'b1, 1'b1, 26'd0, 12'd0},
		// new block opens positive after a negative: no crossing there
		'{16'sd100,  1'b0, 1'b0, 26'd0, 12'd0},
		'{-16'sd1,   1'b0, 1'b0, 26'd0, 12'd0},
		'{16'sh7FFF, 1'b0, 1'b0, 26'd0, 12'd0},
		'{16'sh8000, 1'b0, 1'b0, 26'd0, 12'd0},
		'{16'sh0000, 1'b0, 1'b0, 26'd0, 12'd0},
		'{-16'sd1,   1'b0, 1'b0, 26'd0, 12'd0},
		'{16'sh7FFF, 1'b1, 1'b0, 26'd0, 12'd0},
		// zero and positives only: zero is not negative
		'{16'sh0000, 1'b0, 1'b0, 26'd0, 12'd0},
		'{16'sd1,    1'b0, 1'b0, 26'd0, 12'd0},
		'{16'sh0000, 1'b1, 1'b1, 26'd0, 12'd0},
		// two crossings onto zero, two words apart
		'{-16'sd1,   1'b0, 1'b0, 26'd0, 12'd0},
		'{16'sh0000, 1'b0, 1'b0, 26'd0, 12'd0},
		'{-16'sd1,   1'b0, 1'b0, 26'd0, 12'd0},
		'{16'sh0000, 1'b1, 1'b0, 26'd0, 12'd0},
		// tightest span: largest then smallest fraction
		'{16'sh8000, 1'b0, 1'b0, 26'd0, 12'd0},
		'{16'sh0000, 1'b0, 1'b0, 26'd0, 12'd0},
		'{-16'sd1,   1'b0, 1'b0, 26'd0, 12'd0},
		'{16'sh7FFF, 1'b1, 1'b0, 26'd0, 12'd0}
	};

	zero_crossing_frequency_estimator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.last_sample  (last_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frequency_q8 (frequency_q8),
		.crossings    (crossings)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still pending", $realtime,
				expected_blocks.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Predictor: feeds one accepted word into the block state. Returns 1 with
	// the block's frequency and count when the word closes the block.
	function automatic bit predict_sample(input logic signed [SMP_W-1:0] cur,
			input logic last, output block_result_t res);
		longint signed   neg_prev;
		longint signed   diff;
		longint unsigned pos;
		longint unsigned span;
		longint unsigned num;
		longint unsigned freq;
		res = '0;
		// upward crossing: negative to zero or more, never on a block's first word
		// and not once the index has clamped at the block limit
		if (est_have_prev && est_index < MAX_BLOCK_DEF && est_prev < 0 && cur >= 0) begin
			neg_prev = -longint'(est_prev);
			diff = longint'(cur) - longint'(est_prev);  // at least 1
			pos = ((longint'(est_index) - 1) << FRAC_W) + ((neg_prev << FRAC_W) / diff);
			if (!est_first_seen) begin
				est_first_pos = pos;
				est_first_seen = 1'b1;
			end
			est_last_pos = pos;
			if (est_count < COUNT_MAX)
				est_count++;
		end
		est_prev = cur;
		est_have_prev = 1'b1;
		if (est_index < MAX_BLOCK_DEF)
			est_index++;
		if (!last)
			return 1'b0;
		freq = 0;
		if (est_count >= 2 && est_last_pos > est_first_pos) begin
			span = est_last_pos - est_first_pos;
			num = longint'(est_count - 1) * longint'(est_rate);
			num = num << (FRAC_W + OUT_FRAC_W);
			freq = num / span;
			if (freq > FREQ_MAX)
				freq = FREQ_MAX;
		end
		res.freq = freq[QUO_W-1:0];
		res.count = est_count[CNT_W-1:0];
		// fresh block
		est_prev = '0;
		est_have_prev = 1'b0;
		est_index = 0;
		est_first_pos = 0;
		est_first_seen = 1'b0;
		est_last_pos = 0;
		est_count = 0;
		return 1'b1;
	endfunction

	// APB transfer: setup then access, done on the edge with pready high.
	// Called and returns at a falling edge.
	task automatic apb_xfer(input bit wr, input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = addr;
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Offer one word; optional idle burst first. Valid holds until accepted.
	task automatic send_word(input logic signed [SMP_W-1:0] s, input logic l,
			input bit typed, input block_result_t typed_res);
		block_result_t res;
		int unsigned gap;
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			in_valid = 1'b0;
			gap = $urandom_range(1, 17);
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		sample = s;
		last_sample = l;
		do @(posedge clk); while (!in_ready);
		if (predict_sample(s, l, res))
			expected_blocks.push_back(typed ? typed_res : res);
		@(negedge clk);
	endtask

	// Random block: mostly a square-ish wave with random levels so crossings
	// come regularly; some full-range noise and some very short blocks.
	task automatic send_random_block(output int unsigned len);
		int unsigned kind;
		int unsigned period;
		int unsigned neg_len;
		int unsigned offs;
		int unsigned amp;
		int unsigned k;
		logic signed [SMP_W-1:0] s;
		kind = $urandom_range(0, 9);
		len = (kind == 0) ? $urandom_range(1, 3) : $urandom_range(4, 36);
		period = $urandom_range(2, 9);
		neg_len = $urandom_range(1, period - 1);
		offs = $urandom_range(0, period - 1);
		case ($urandom_range(0, 3))
			0: amp = 1;
			1: amp = 32767;
			default: amp = $urandom_range(2, 32766);
		endcase
		for (k = 0; k < len; k++) begin
			if (kind < 2)
				s = SMP_W'($urandom);
			else if (((k + offs) % period) < neg_len)
				s = SMP_W'(-int'($urandom_range(1, amp + 1)));
			else
				s = SMP_W'($urandom_range(0, amp));
			send_word(s, k == len - 1, 1'b0, '0);
		end
	endtask

	// Wait until every pending result is in, then let in-flight divides finish
	task automatic drain_results();
		while (expected_blocks.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Receiver: random stall bursts, plus one long counted hold-off on request
	initial begin : rx_side
		int unsigned n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_cycles != 0) begin
				out_ready = 1'b0;
				n = rx_hold_cycles;
				rx_hold_cycles = 0;
				repeat (n) @(negedge clk);
			end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
				out_ready = 1'b0;
				n = $urandom_range(1, 17);
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Result checker: each accepted word against the oldest expectation
	always @(posedge clk) begin : result_check
		block_result_t want;
		if (out_valid && out_ready) begin
			if (expected_blocks.size() == 0) begin
				$display("%0t: result with none expected, frequency_q8 %0d crossings %0d",
					$realtime, frequency_q8, crossings);
				mismatches++;
			end else begin
				want = expected_blocks.pop_front();
				if (frequency_q8 !== want.freq) begin
					$display("%0t: frequency_q8 expected %0d actual %0d",
						$realtime, want.freq, frequency_q8);
					mismatches++;
				end
				if (crossings !== want.count) begin
					$display("%0t: crossings expected %0d actual %0d",
						$realtime, want.count, crossings);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned p;
		int unsigned sent;
		int unsigned n;
		logic [APB_DATA_W-1:0] rd;
		block_result_t typed_res;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// register must come up at its reset value
		apb_xfer(1'b0, RATE_ADDR, '0, rd);
		if (rd !== APB_DATA_W'(est_rate)) begin
			$display("%0t: sample_rate after reset expected %0d actual %0d",
				$realtime, est_rate, rd);
			mismatches++;
		end

		// directed words at the reset rate
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		foreach (directed_rows[i]) begin
			typed_res.freq = directed_rows[i].freq;
			typed_res.count = directed_rows[i].count;
			send_word(directed_rows[i].smp, directed_rows[i].last,
				directed_rows[i].typed, typed_res);
		end
		in_valid = 1'b0;
		drain_results();

		// random phases, each at its own rate; the block is idle at each write
		for (p = 0; p < NUM_PHASES; p++) begin
			apb_xfer(1'b1, RATE_ADDR, APB_DATA_W'(phase_rate[p]), rd);
			est_rate = phase_rate[p] & ((1 << RATE_W) - 1);
			apb_xfer(1'b0, RATE_ADDR, '0, rd);
			if (rd !== APB_DATA_W'(est_rate)) begin
				$display("%0t: sample_rate readback expected %0d actual %0d",
					$realtime, est_rate, rd);
				mismatches++;
			end
			tx_idle_pct = phase_tx_idle[p];
			rx_idle_pct = phase_rx_idle[p];
			// sender keeps offering while the receiver sits out a long stretch
			if (p == HOLD_PHASE)
				rx_hold_cycles = HOLD_CYCLES;
			sent = 0;
			while (sent < phase_items[p]) begin
				send_random_block(n);
				sent += n;
			end
			in_valid = 1'b0;
			drain_results();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
